// ===== rtl/erdm_pkg.sv =====
package erdm_pkg;

  // default sizes of the route and group stores
  localparam int ROUTES_PER_SOURCE_DEF = 256;
  localparam int GROUP_COUNT_DEF       = 128;
  localparam int EXPERTS_PER_LAYER_DEF = 64;
  localparam int SOURCE_COUNT_DEF      = 2;

  // field widths on the stream ports
  localparam int REQ_W    = 3;
  localparam int POS_W    = 8;
  localparam int ID_W     = 8;
  localparam int GSEL_W   = 7;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 9;
  localparam int END_W    = 10;
  localparam int TOTAL_W  = 10;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_START     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ_SLOT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_END  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_ID   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_DONE = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_OWNER    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LAST_END = 1'd1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ZERO,
    S_CNT_RD,
    S_CNT_GRP,
    S_CNT_WR,
    S_SUM_RD,
    S_SUM_WR,
    S_SLOT_RD,
    S_SLOT_GRP,
    S_SLOT_WR,
    S_RESP
  } erdm_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_ROUTE,
    OP_ACCEPT,
    OP_ZERO_CNT,
    OP_ROUTE_RD,
    OP_CNT_RD,
    OP_CNT_INC,
    OP_SUM_RD,
    OP_SUM_WR,
    OP_SLOT_WR,
    OP_RESPOND
  } erdm_op_t;

  typedef struct packed {
    erdm_op_t op;
    logic     rc_inc;
    logic     gc_inc;
  } erdm_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             out_free;
    logic             rc_last;
    logic             gc_last;
    logic             err;
    logic             owned;
  } erdm_sts_t;

endpackage

// ===== rtl/expert_route_dispatch_map_core.sv =====
// start/load/unknown answer in the cycle after acceptance; loads go at 1 per cycle while
// out_tready is high; reads answer from S_RESP after the registered memory read, once the
// result register is free, one request at a time; finish runs count clear, per-route count
// read-modify-write, running-end sweep, per-route slot assignment; after a bad id the
// per-route passes are skipped; reset (synchronous, rst_n low) and each start request
// clear the route store; no request is taken then, configuration writes are always taken
module expert_route_dispatch_map_core
  import erdm_pkg::*;
#(
  parameter int ROUTES_PER_SOURCE = ROUTES_PER_SOURCE_DEF,
  parameter int GROUP_COUNT       = GROUP_COUNT_DEF,
  parameter int EXPERTS_PER_LAYER = EXPERTS_PER_LAYER_DEF,
  parameter int SOURCE_COUNT      = SOURCE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // source_sel, route_pos, layer_sel, expert_id, group_sel
  input  logic [REQ_W-1:0]      in_tuser,   // req_type
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slot_valid, slot_index, group_end, total_routes
  output logic [STATUS_W-1:0]   out_tuser,  // status_code
  // configuration writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // controller sequences the passes, datapath owns the stores and the result register
  erdm_cmd_t cmd;
  erdm_sts_t sts;

  erdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // route, slot, count and end stores live in the datapath
  erdm_dpath #(
    .ROUTES_PER_SOURCE (ROUTES_PER_SOURCE),
    .GROUP_COUNT       (GROUP_COUNT),
    .EXPERTS_PER_LAYER (EXPERTS_PER_LAYER),
    .SOURCE_COUNT      (SOURCE_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/erdm_ram.sv =====
module erdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/erdm_ctrl.sv =====
module erdm_ctrl
  import erdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  erdm_sts_t sts,
  output erdm_cmd_t cmd
);

  erdm_state_t state_r, state_nxt;
  logic        fire;

  assign in_tready = (state_r == S_IDLE) && sts.out_free;
  assign fire      = in_tready && in_tvalid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.rc_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (fire) begin
          case (sts.req)
            REQ_START:     state_nxt = S_CLEAR;
            REQ_FINISH:    state_nxt = S_ZERO;
            REQ_READ_SLOT: state_nxt = S_RESP;
            REQ_READ_END:  state_nxt = S_RESP;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_ZERO: begin
        if (sts.gc_last) state_nxt = sts.err ? S_SUM_RD : S_CNT_RD;
      end
      S_CNT_RD:  state_nxt = S_CNT_GRP;
      S_CNT_GRP: begin
        if (sts.owned) state_nxt = S_CNT_WR;
        else if (sts.rc_last) state_nxt = S_SUM_RD;
        else state_nxt = S_CNT_RD;
      end
      S_CNT_WR:  state_nxt = sts.rc_last ? S_SUM_RD : S_CNT_RD;
      S_SUM_RD:  state_nxt = S_SUM_WR;
      S_SUM_WR: begin
        if (sts.gc_last) state_nxt = sts.err ? S_RESP : S_SLOT_RD;
        else state_nxt = S_SUM_RD;
      end
      S_SLOT_RD:  state_nxt = S_SLOT_GRP;
      S_SLOT_GRP: begin
        if (sts.owned) state_nxt = S_SLOT_WR;
        else if (sts.rc_last) state_nxt = S_RESP;
        else state_nxt = S_SLOT_RD;
      end
      S_SLOT_WR: state_nxt = sts.rc_last ? S_RESP : S_SLOT_RD;
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '{op: OP_NONE, rc_inc: 1'b0, gc_inc: 1'b0};
    case (state_r)
      S_CLEAR: begin
        cmd.op     = OP_CLR_ROUTE;
        cmd.rc_inc = 1'b1;
      end
      S_IDLE: begin
        if (fire) cmd.op = OP_ACCEPT;
      end
      S_ZERO: begin
        cmd.op     = OP_ZERO_CNT;
        cmd.gc_inc = 1'b1;
      end
      S_CNT_RD:  cmd.op = OP_ROUTE_RD;
      S_SLOT_RD: cmd.op = OP_ROUTE_RD;
      S_CNT_GRP, S_SLOT_GRP: begin
        if (sts.owned) cmd.op = OP_CNT_RD;
        else cmd.rc_inc = 1'b1;
      end
      S_CNT_WR: begin
        cmd.op     = OP_CNT_INC;
        cmd.rc_inc = 1'b1;
      end
      S_SUM_RD: cmd.op = OP_SUM_RD;
      S_SUM_WR: begin
        cmd.op     = OP_SUM_WR;
        cmd.gc_inc = 1'b1;
      end
      S_SLOT_WR: begin
        cmd.op     = OP_SLOT_WR;
        cmd.rc_inc = 1'b1;
      end
      S_RESP: begin
        if (sts.out_free) cmd.op = OP_RESPOND;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sts.req == REQ_START) |=> state_r == S_CLEAR)
    else $error("start request did not enter the clearing pass");

  a_finish_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && sts.req == REQ_FINISH) |=> state_r == S_ZERO)
    else $error("finish request did not begin with the count clear");

  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && !sts.rc_last) |=> state_r == S_CLEAR)
    else $error("clearing pass left before the last route");

endmodule

// ===== rtl/erdm_dpath.sv =====
module erdm_dpath
  import erdm_pkg::*;
#(
  parameter int ROUTES_PER_SOURCE = ROUTES_PER_SOURCE_DEF,
  parameter int GROUP_COUNT       = GROUP_COUNT_DEF,
  parameter int EXPERTS_PER_LAYER = EXPERTS_PER_LAYER_DEF,
  parameter int SOURCE_COUNT      = SOURCE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [REQ_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  erdm_cmd_t             cmd,
  output erdm_sts_t             sts
);

  localparam int RouteDepth = SOURCE_COUNT * ROUTES_PER_SOURCE;
  localparam int IW = $clog2(RouteDepth);
  localparam int GW = $clog2(GROUP_COUNT);
  localparam int CW = $clog2(RouteDepth + 1);
  localparam logic [8:0]  IdLimit  = 9'(2 * EXPERTS_PER_LAYER);
  localparam logic [8:0]  EplW     = 9'(EXPERTS_PER_LAYER);
  localparam logic [8:0]  GrpLimit = 9'(GROUP_COUNT);
  localparam logic [8:0]  GrpLast  = 9'(GROUP_COUNT - 1);
  localparam logic [2:0]  SrcLimit = 3'(SOURCE_COUNT);
  localparam logic [10:0] PosLimit = 11'(ROUTES_PER_SOURCE);
  localparam logic [END_W-1:0] LastEnd = END_W'(2 * ROUTES_PER_SOURCE);

  // input fields
  logic              f_src;
  logic [POS_W-1:0]  f_pos;
  logic              f_layer;
  logic [ID_W-1:0]   f_id;
  logic [GSEL_W-1:0] f_gsel;

  assign f_src   = in_tdata[0];
  assign f_pos   = in_tdata[8:1];
  assign f_layer = in_tdata[9];
  assign f_id    = in_tdata[17:10];
  assign f_gsel  = in_tdata[24:18];

  // route decode
  logic            id_bad, id_hi, grp_ok, own, in_range, gsel_ok, gsel_last;
  logic [ID_W-1:0] id_mod;
  logic [8:0]      grp9;
  logic [IW-1:0]   idx;

  assign id_bad    = {1'b0, f_id} >= IdLimit;
  assign id_hi     = {1'b0, f_id} >= EplW;
  assign id_mod    = id_hi ? f_id - ID_W'(EXPERTS_PER_LAYER) : f_id;
  assign grp9      = (f_layer ? EplW : 9'd0) + {1'b0, id_mod};
  assign grp_ok    = grp9 < GrpLimit;
  assign in_range  = ({2'b0, f_src} < SrcLimit) && ({3'b0, f_pos} < PosLimit);
  assign idx       = (f_src ? IW'(ROUTES_PER_SOURCE) : '0) + IW'(f_pos);
  assign gsel_ok   = {2'b0, f_gsel} < GrpLimit;
  assign gsel_last = {2'b0, f_gsel} == GrpLast;

  // configuration and batch state
  logic          owner_r, force_end_r;
  logic          err_r, err_nxt;
  logic          fin_r, fin_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [IW-1:0] rc_r;
  logic [GW-1:0] gc_r;
  logic          rc_last, gc_last;

  assign own     = !id_bad && (id_hi == owner_r) && grp_ok;
  assign rc_last = rc_r == IW'(RouteDepth - 1);
  assign gc_last = gc_r == GW'(GROUP_COUNT - 1);

  // request held for the response
  logic [REQ_W-1:0] req_r;
  logic             in_range_r, gsel_ok_r, gsel_last_r;

  // memory ports
  logic            rt_we, rt_re;
  logic [IW-1:0]   rt_waddr, rt_raddr;
  logic [GW:0]     rt_wdata, rt_rdata;
  logic            sl_we, sl_re;
  logic [IW-1:0]   sl_waddr, sl_raddr;
  logic [IW-1:0]   sl_wdata, sl_rdata;
  logic            ct_we, ct_re;
  logic [GW-1:0]   ct_waddr, ct_raddr;
  logic [CW-1:0]   ct_wdata, ct_rdata;
  logic            en_we, en_re;
  logic [GW-1:0]   en_waddr, en_raddr;
  logic [CW-1:0]   en_wdata, en_rdata;

  logic          rt_owned;
  logic [GW-1:0] rt_grp;

  assign rt_owned = rt_rdata[GW];
  assign rt_grp   = rt_rdata[GW-1:0];

  // result register
  logic                out_valid_r, out_valid_nxt, load_out, out_free;
  logic [STATUS_W-1:0] res_status, out_status_r;
  logic                res_valid, out_slot_valid_r;
  logic [SLOT_W-1:0]   res_slot, out_slot_r;
  logic [END_W-1:0]    res_end, out_end_r;
  logic [TOTAL_W-1:0]  res_total, out_total_r;
  logic                immediate;

  assign out_free  = !out_valid_r || out_tready;
  assign immediate = (in_tuser != REQ_FINISH) && (in_tuser != REQ_READ_SLOT)
                     && (in_tuser != REQ_READ_END);

  always_comb begin
    rt_we = 1'b0; rt_re = 1'b0; rt_waddr = rc_r; rt_raddr = rc_r; rt_wdata = '0;
    sl_we = 1'b0; sl_re = 1'b0; sl_waddr = rc_r; sl_raddr = idx;
    sl_wdata = IW'(ct_rdata);
    ct_we = 1'b0; ct_re = 1'b0; ct_waddr = gc_r; ct_raddr = gc_r; ct_wdata = '0;
    en_we = 1'b0; en_re = 1'b0; en_waddr = gc_r; en_raddr = GW'(f_gsel);
    en_wdata = run_r + ct_rdata;
    err_nxt = err_r;
    fin_nxt = fin_r;
    run_nxt = run_r;
    load_out = 1'b0;
    res_status = err_r ? STAT_BAD_ID : STAT_OK;
    res_valid  = 1'b0;
    res_slot   = '0;
    res_end    = '0;
    res_total  = '0;
    case (cmd.op)
      OP_CLR_ROUTE: rt_we = 1'b1;
      OP_ACCEPT: begin
        case (in_tuser)
          REQ_START: begin
            err_nxt = 1'b0;
            fin_nxt = 1'b0;
            run_nxt = '0;
            res_status = STAT_OK;
          end
          REQ_LOAD: begin
            rt_we    = in_range;
            rt_waddr = idx;
            rt_wdata = {own, own ? GW'(grp9) : '0};
            err_nxt  = err_r || id_bad;
            fin_nxt  = 1'b0;
            res_status = (err_r || id_bad) ? STAT_BAD_ID : STAT_OK;
          end
          REQ_FINISH: run_nxt = '0;
          REQ_READ_SLOT: begin
            rt_re    = 1'b1;
            rt_raddr = idx;
            sl_re    = 1'b1;
          end
          REQ_READ_END: en_re = 1'b1;
          default: fin_nxt = fin_r;
        endcase
        load_out = immediate;
      end
      OP_ZERO_CNT: ct_we = 1'b1;
      OP_ROUTE_RD: rt_re = 1'b1;
      OP_CNT_RD: begin
        ct_re    = 1'b1;
        ct_raddr = rt_grp;
      end
      OP_CNT_INC: begin
        ct_we    = 1'b1;
        ct_waddr = rt_grp;
        ct_wdata = ct_rdata + CW'(1);
      end
      OP_SUM_RD: ct_re = 1'b1;
      OP_SUM_WR: begin
        // count becomes the group's start cursor
        ct_we    = 1'b1;
        ct_wdata = run_r;
        en_we    = 1'b1;
        run_nxt  = run_r + ct_rdata;
      end
      OP_SLOT_WR: begin
        sl_we    = 1'b1;
        ct_we    = 1'b1;
        ct_waddr = rt_grp;
        ct_wdata = ct_rdata + CW'(1);
      end
      OP_RESPOND: begin
        load_out = 1'b1;
        if (req_r == REQ_FINISH) begin
          fin_nxt   = 1'b1;
          res_total = TOTAL_W'(run_r);
        end else if (!fin_r) begin
          res_status = STAT_NOT_DONE;
        end else begin
          res_total = TOTAL_W'(run_r);
          if (req_r == REQ_READ_SLOT) begin
            res_valid = in_range_r && rt_owned && !err_r;
            res_slot  = res_valid ? SLOT_W'(sl_rdata) : '0;
          end else if (gsel_ok_r) begin
            res_end = (gsel_last_r && force_end_r) ? LastEnd : END_W'(en_rdata);
          end
        end
      end
      default: load_out = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r     <= 1'b0;
      force_end_r <= 1'b1;
      err_r       <= 1'b0;
      fin_r       <= 1'b0;
      run_r       <= '0;
      rc_r        <= '0;
      gc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_LOCAL_OWNER) owner_r <= cfg_data[0];
      if (cfg_wr_en && cfg_index == CFG_FORCE_LAST_END) force_end_r <= cfg_data[0];
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      run_r       <= run_nxt;
      if (cmd.rc_inc) rc_r <= rc_last ? '0 : rc_r + IW'(1);
      if (cmd.gc_inc) gc_r <= gc_last ? '0 : gc_r + GW'(1);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      req_r       <= in_tuser;
      in_range_r  <= in_range;
      gsel_ok_r   <= gsel_ok;
      gsel_last_r <= gsel_last;
    end
    if (load_out) begin
      out_status_r     <= res_status;
      out_slot_valid_r <= res_valid;
      out_slot_r       <= res_slot;
      out_end_r        <= res_end;
      out_total_r      <= res_total;
    end
  end

  erdm_ram #(.WIDTH(GW + 1), .DEPTH(RouteDepth)) u_route_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .re(rt_re), .raddr(rt_raddr), .rdata(rt_rdata)
  );

  erdm_ram #(.WIDTH(IW), .DEPTH(RouteDepth)) u_slot_ram (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .re(sl_re), .raddr(sl_raddr), .rdata(sl_rdata)
  );

  erdm_ram #(.WIDTH(CW), .DEPTH(GROUP_COUNT)) u_count_ram (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .re(ct_re), .raddr(ct_raddr), .rdata(ct_rdata)
  );

  erdm_ram #(.WIDTH(CW), .DEPTH(GROUP_COUNT)) u_end_ram (
    .clk(clk), .we(en_we), .waddr(en_waddr), .wdata(en_wdata),
    .re(en_re), .raddr(en_raddr), .rdata(en_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_total_r, out_end_r, out_slot_r, out_slot_valid_r};

  assign sts = '{req: in_tuser, out_free: out_free, rc_last: rc_last,
                 gc_last: gc_last, err: err_r, owned: rt_owned};

  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_r && err_r) |-> run_r == '0)
    else $error("finished map after a bad id holds routes");

  a_slot_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_slot_valid_r) |-> out_status_r == STAT_OK)
    else $error("slot answered with a non-ok status");

endmodule
